// ===== sv/cdt_pkg.sv =====
// Shared types and constants for the cube direction to texel block.
// No dependencies; every other file in this folder imports it.
package cdt_pkg;

  localparam int FieldBits        = 16;
  localparam int DefFaceSize      = 16;
  localparam int DefComponentBits = 16;

  localparam logic [2:0] FacePosX = 3'd0;
  localparam logic [2:0] FaceNegX = 3'd1;
  localparam logic [2:0] FacePosY = 3'd2;
  localparam logic [2:0] FaceNegY = 3'd3;
  localparam logic [2:0] FacePosZ = 3'd4;
  localparam logic [2:0] FaceNegZ = 3'd5;

  typedef struct packed {
    logic signed [FieldBits-1:0] dir_x;
    logic signed [FieldBits-1:0] dir_y;
    logic signed [FieldBits-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [10:0] texel_index;
    logic [2:0]  face_number;
    logic [3:0]  column;
    logic [3:0]  row;
    logic        degenerate;
  } texel_t;

  // travels with each item through the pipeline
  typedef struct packed {
    logic [2:0] face;
    logic       degen;
  } tag_t;

endpackage

// ===== sv/cdt_select.sv =====
// Major axis selection: picks the face and the signed in-face numerators.
// Depends on cdt_pkg.
module cdt_select #(
  parameter int ComponentBits = cdt_pkg::DefComponentBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  cdt_pkg::dir_t              dir_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output cdt_pkg::tag_t              tag_o,
  output logic signed [ComponentBits:0] nu_o,
  output logic signed [ComponentBits:0] nv_o,
  output logic [ComponentBits-1:0]   mag_o
);
  import cdt_pkg::*;

  localparam int CB = ComponentBits;
  localparam int EW = (CB > FieldBits) ? CB : FieldBits;

  function automatic logic signed [CB:0] read_comp(input logic [FieldBits-1:0] raw);
    logic [EW-1:0] ext;
    logic [CB-1:0] bits;
    ext  = EW'(raw);
    bits = ext[CB-1:0];
    return {bits[CB-1], bits};
  endfunction

  function automatic logic [CB:0] mag(input logic signed [CB:0] v);
    return v[CB] ? (CB+1)'(-v) : (CB+1)'(v);
  endfunction

  logic signed [CB:0] xs, ys, zs;
  logic [CB:0]        ax, ay, az;
  logic               x_pos, y_pos, z_pos;

  tag_t               tag_d, tag_q;
  logic signed [CB:0] nu_d, nu_q, nv_d, nv_q;
  logic [CB-1:0]      mag_d, mag_q;
  logic               valid_q;

  always_comb begin
    xs    = read_comp(dir_i.dir_x);
    ys    = read_comp(dir_i.dir_y);
    zs    = read_comp(dir_i.dir_z);
    ax    = mag(xs);
    ay    = mag(ys);
    az    = mag(zs);
    x_pos = !xs[CB] && (xs != '0);
    y_pos = !ys[CB] && (ys != '0);
    z_pos = !zs[CB] && (zs != '0);

    tag_d.degen = (ax == '0) && (ay == '0) && (az == '0);
    // ties go to X, then Y
    if (ax >= ay && ax >= az) begin
      tag_d.face = x_pos ? FacePosX : FaceNegX;
      nu_d       = x_pos ? -zs : zs;
      nv_d       = -ys;
      mag_d      = ax[CB-1:0];
    end else if (ay >= az) begin
      tag_d.face = y_pos ? FacePosY : FaceNegY;
      nu_d       = xs;
      nv_d       = y_pos ? zs : -zs;
      mag_d      = ay[CB-1:0];
    end else begin
      tag_d.face = z_pos ? FacePosZ : FaceNegZ;
      nu_d       = z_pos ? xs : -xs;
      nv_d       = -ys;
      mag_d      = az[CB-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_q <= tag_d;
      nu_q  <= nu_d;
      nv_q  <= nv_d;
      mag_q <= mag_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign nu_o    = nu_q;
  assign nv_o    = nv_q;
  assign mag_o   = mag_q;

  a_degen_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && tag_q.degen |-> (mag_q == '0) && (tag_q.face == FaceNegX))
    else $error("degenerate item with nonzero major magnitude");

  a_live_nonzero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !tag_q.degen |-> (mag_q != '0))
    else $error("non-degenerate item with zero major magnitude");

endmodule

// ===== sv/cdt_scale.sv =====
// Forms the division operands: numerator (n + a) * FaceSize, divisor 2a.
// Depends on cdt_pkg.
module cdt_scale #(
  parameter int ComponentBits = cdt_pkg::DefComponentBits,
  parameter int FaceSize      = cdt_pkg::DefFaceSize,
  localparam int QB = $clog2(FaceSize + 1),
  localparam int NW = ComponentBits + 1 + QB
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  cdt_pkg::tag_t                 tag_i,
  input  logic signed [ComponentBits:0] nu_i,
  input  logic signed [ComponentBits:0] nv_i,
  input  logic [ComponentBits-1:0]      mag_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output cdt_pkg::tag_t                 tag_o,
  output logic [NW-1:0]                 num_u_o,
  output logic [NW-1:0]                 num_v_o,
  output logic [ComponentBits:0]        den_o
);
  import cdt_pkg::*;

  localparam int CB = ComponentBits;

  logic signed [CB+1:0] sum_u, sum_v;
  logic [NW-1:0]        num_u_d, num_v_d, num_u_q, num_v_q;
  logic [CB:0]          den_q;
  tag_t                 tag_q;
  logic                 valid_q;

  // n + a lies in [0, 2a], so the low CB+1 bits hold it unsigned
  always_comb begin
    sum_u   = {nu_i[CB], nu_i} + $signed({2'b00, mag_i});
    sum_v   = {nv_i[CB], nv_i} + $signed({2'b00, mag_i});
    num_u_d = NW'(sum_u[CB:0]) * NW'(FaceSize);
    num_v_d = NW'(sum_v[CB:0]) * NW'(FaceSize);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_q   <= tag_i;
      num_u_q <= num_u_d;
      num_v_q <= num_v_d;
      den_q   <= {mag_i, 1'b0};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign den_o   = den_q;

endmodule

// ===== sv/cdt_div_cell.sv =====
// One restoring-division cell: retires quotient bit Bit for both coordinates.
// Depends on cdt_pkg.
module cdt_div_cell #(
  parameter int ComponentBits = cdt_pkg::DefComponentBits,
  parameter int FaceSize      = cdt_pkg::DefFaceSize,
  parameter int Bit           = 0,
  localparam int QB = $clog2(FaceSize + 1),
  localparam int NW = ComponentBits + 1 + QB
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  cdt_pkg::tag_t          tag_i,
  input  logic [NW-1:0]          num_u_i,
  input  logic [NW-1:0]          num_v_i,
  input  logic [ComponentBits:0] den_i,
  input  logic [QB-1:0]          quo_u_i,
  input  logic [QB-1:0]          quo_v_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output cdt_pkg::tag_t          tag_o,
  output logic [NW-1:0]          num_u_o,
  output logic [NW-1:0]          num_v_o,
  output logic [ComponentBits:0] den_o,
  output logic [QB-1:0]          quo_u_o,
  output logic [QB-1:0]          quo_v_o
);
  import cdt_pkg::*;

  logic [NW-1:0] den_sh;
  logic          ge_u, ge_v;
  logic [NW-1:0] num_u_d, num_v_d, num_u_q, num_v_q;
  logic [QB-1:0] quo_u_d, quo_v_d, quo_u_q, quo_v_q;
  logic [ComponentBits:0] den_q;
  tag_t          tag_q;
  logic          valid_q;

  always_comb begin
    den_sh  = NW'(den_i) << Bit;
    ge_u    = num_u_i >= den_sh;
    ge_v    = num_v_i >= den_sh;
    num_u_d = ge_u ? num_u_i - den_sh : num_u_i;
    num_v_d = ge_v ? num_v_i - den_sh : num_v_i;
    quo_u_d = quo_u_i;
    quo_v_d = quo_v_i;
    quo_u_d[Bit] = ge_u;
    quo_v_d[Bit] = ge_v;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_q   <= tag_i;
      num_u_q <= num_u_d;
      num_v_q <= num_v_d;
      den_q   <= den_i;
      quo_u_q <= quo_u_d;
      quo_v_q <= quo_v_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign den_o   = den_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;

  // partial remainder must stay below the shifted divisor
  a_rem_u_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !tag_q.degen |-> num_u_q < (NW'(den_q) << Bit))
    else $error("u remainder out of range after division cell");

  a_rem_v_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !tag_q.degen |-> num_v_q < (NW'(den_q) << Bit))
    else $error("v remainder out of range after division cell");

endmodule

// ===== sv/cdt_addr.sv =====
// Clamps the quotients to the face and builds the texel index; output register.
// Depends on cdt_pkg.
module cdt_addr #(
  parameter int FaceSize = cdt_pkg::DefFaceSize,
  localparam int QB = $clog2(FaceSize + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cdt_pkg::tag_t    tag_i,
  input  logic [QB-1:0]    quo_u_i,
  input  logic [QB-1:0]    quo_v_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cdt_pkg::texel_t  texel_o
);
  import cdt_pkg::*;

  localparam int MaxCoord  = FaceSize - 1;
  localparam int HalfCoord = (FaceSize / 2 < MaxCoord) ? FaceSize / 2 : MaxCoord;

  logic [QB-1:0] t_u, t_v;
  logic [31:0]   idx_full;
  texel_t        texel_d, texel_q;
  logic          valid_q;

  always_comb begin
    // zero vector: both ratios count as zero, i.e. mid-face
    if (tag_i.degen) begin
      t_u = QB'(HalfCoord);
      t_v = QB'(HalfCoord);
    end else begin
      t_u = (quo_u_i > QB'(MaxCoord)) ? QB'(MaxCoord) : quo_u_i;
      t_v = (quo_v_i > QB'(MaxCoord)) ? QB'(MaxCoord) : quo_v_i;
    end
    idx_full = 32'(tag_i.face) * 32'(FaceSize * FaceSize)
             + 32'(t_v) * 32'(FaceSize) + 32'(t_u);
    texel_d.texel_index = idx_full[10:0];
    texel_d.face_number = tag_i.face;
    texel_d.column      = 4'(t_u);
    texel_d.row         = 4'(t_v);
    texel_d.degenerate  = tag_i.degen;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      texel_q <= texel_d;
    end
  end

  assign valid_o = valid_q;
  assign texel_o = texel_q;

  a_degen_mid_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && texel_q.degenerate |->
      (texel_q.face_number == FaceNegX) && (texel_q.column == texel_q.row))
    else $error("degenerate result not on -X mid-face");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> texel_q.face_number <= FaceNegZ)
    else $error("face number out of range");

endmodule

// ===== sv/cube_direction_to_texel_top.sv =====
// Cube map texel lookup: major-axis select, operand scaling, a chain of
// $clog2(FaceSize+1) restoring-division cells (one quotient bit each) and an
// output register. Throughput one transfer per cycle unless the output stalls;
// every stage has its own valid and ready, so bubbles collapse and a held result
// stalls the input only once all stages hold data. Reset clears the stage valid
// flags only. Depends on cdt_pkg and submodules.
module cube_direction_to_texel_top #(
  parameter int FaceSize      = cdt_pkg::DefFaceSize,
  parameter int ComponentBits = cdt_pkg::DefComponentBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cdt_pkg::dir_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cdt_pkg::texel_t out_data_o
);
  import cdt_pkg::*;

  localparam int CB = ComponentBits;
  localparam int QB = $clog2(FaceSize + 1);
  localparam int NW = CB + 1 + QB;

  logic               sel_valid, sel_ready;
  tag_t               sel_tag;
  logic signed [CB:0] sel_nu, sel_nv;
  logic [CB-1:0]      sel_mag;

  logic          valid_s [0:QB];
  logic          ready_s [0:QB];
  tag_t          tag_s   [0:QB];
  logic [NW-1:0] num_u_s [0:QB];
  logic [NW-1:0] num_v_s [0:QB];
  logic [CB:0]   den_s   [0:QB];
  logic [QB-1:0] quo_u_s [0:QB];
  logic [QB-1:0] quo_v_s [0:QB];

  cdt_select #(
    .ComponentBits(CB)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .dir_i   (in_data_i),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .tag_o   (sel_tag),
    .nu_o    (sel_nu),
    .nv_o    (sel_nv),
    .mag_o   (sel_mag)
  );

  cdt_scale #(
    .ComponentBits(CB),
    .FaceSize     (FaceSize)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .tag_i   (sel_tag),
    .nu_i    (sel_nu),
    .nv_i    (sel_nv),
    .mag_i   (sel_mag),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .tag_o   (tag_s[0]),
    .num_u_o (num_u_s[0]),
    .num_v_o (num_v_s[0]),
    .den_o   (den_s[0])
  );

  assign quo_u_s[0] = '0;
  assign quo_v_s[0] = '0;

  // most significant quotient bit first
  for (genvar i = 0; i < QB; i++) begin : g_div
    cdt_div_cell #(
      .ComponentBits(CB),
      .FaceSize     (FaceSize),
      .Bit          (QB - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .tag_i   (tag_s[i]),
      .num_u_i (num_u_s[i]),
      .num_v_i (num_v_s[i]),
      .den_i   (den_s[i]),
      .quo_u_i (quo_u_s[i]),
      .quo_v_i (quo_v_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .tag_o   (tag_s[i+1]),
      .num_u_o (num_u_s[i+1]),
      .num_v_o (num_v_s[i+1]),
      .den_o   (den_s[i+1]),
      .quo_u_o (quo_u_s[i+1]),
      .quo_v_o (quo_v_s[i+1])
    );
  end

  cdt_addr #(
    .FaceSize(FaceSize)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[QB]),
    .ready_o (ready_s[QB]),
    .tag_i   (tag_s[QB]),
    .quo_u_i (quo_u_s[QB]),
    .quo_v_i (quo_v_s[QB]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .texel_o (out_data_o)
  );

endmodule
